@@ hw/rtl/grs_pkg.sv @@
// Shared types, constants and helper functions for the group reverse sequence unit.
`timescale 1ns / 1ps
`default_nettype none

package grs_pkg;

  localparam int unsigned MaxGroup   = 16;
  localparam int unsigned DataWidth  = 32;
  localparam int unsigned SizeWidth  = 5;
  localparam int unsigned AddrWidth  = $clog2(MaxGroup);

  localparam logic [SizeWidth-1:0] GroupSizeReset = SizeWidth'(2);

  typedef enum logic [1:0] {
    StIdle,
    StRead,
    StShow
  } grs_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;   // store the incoming value and decide on emission
    logic read;     // fetch the next result from the group store
    logic advance;  // a result transfer completed, step the index
  } grs_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic emit_go;  // the value being accepted releases a run of results
    logic last;     // the result on the output is the last of its run
  } grs_sts_t;

  // Group size as used: zero behaves as one, larger than the store saturates.
  function automatic logic [SizeWidth-1:0] eff_size(input logic [SizeWidth-1:0] raw);
    logic [SizeWidth-1:0] g;
    g = raw;
    if (g == '0) begin
      g = SizeWidth'(1);
    end
    if (g > SizeWidth'(MaxGroup)) begin
      g = SizeWidth'(MaxGroup);
    end
    return g;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/grs_datapath.sv @@
// Datapath: group size register, group store, fill and read counters, output register.
`timescale 1ns / 1ps
`default_nettype none

module grs_datapath (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [grs_pkg::SizeWidth-1:0]    cfg_wdata_i,
  input  wire logic [grs_pkg::DataWidth-1:0]    value_i,
  input  wire logic                             is_final_i,
  input  wire grs_pkg::grs_cmd_t                cmd_i,
  output grs_pkg::grs_sts_t                     sts_o,
  output logic [grs_pkg::DataWidth-1:0]         out_value_o,
  output logic                                  run_end_o
);

  logic [grs_pkg::SizeWidth-1:0] group_size_q;
  logic [grs_pkg::SizeWidth-1:0] fill_q, fill_d;
  logic [grs_pkg::SizeWidth-1:0] count_q, count_d;
  logic [grs_pkg::AddrWidth-1:0] idx_q, idx_d;
  logic                          rev_q, rev_d;
  logic [grs_pkg::DataWidth-1:0] rd_data_q;
  logic                          last_q;

  logic [grs_pkg::DataWidth-1:0] store_mem [grs_pkg::MaxGroup];

  logic [grs_pkg::SizeWidth-1:0] n_held;
  logic [grs_pkg::SizeWidth-1:0] g_eff;
  logic                          full_group;
  logic [grs_pkg::SizeWidth-1:0] rev_addr;
  logic [grs_pkg::AddrWidth-1:0] rd_addr;
  logic                          idx_last;

  always_comb begin
    g_eff      = grs_pkg::eff_size(group_size_q);
    n_held     = fill_q + grs_pkg::SizeWidth'(1);
    full_group = (n_held >= g_eff);
    rev_addr   = count_q - grs_pkg::SizeWidth'(1) - {1'b0, idx_q};
    rd_addr    = rev_q ? rev_addr[grs_pkg::AddrWidth-1:0] : idx_q;
    idx_last   = ({1'b0, idx_q} == (count_q - grs_pkg::SizeWidth'(1)));

    sts_o.emit_go = full_group | is_final_i;
    sts_o.last    = last_q;

    fill_d  = fill_q;
    count_d = count_q;
    rev_d   = rev_q;
    idx_d   = idx_q;
    if (cmd_i.accept) begin
      if (full_group || is_final_i) begin
        fill_d  = '0;
        count_d = n_held;
        rev_d   = full_group;
        idx_d   = '0;
      end else begin
        fill_d = n_held;
      end
    end
    if (cmd_i.advance) begin
      idx_d = idx_q + grs_pkg::AddrWidth'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      group_size_q <= grs_pkg::GroupSizeReset;
      fill_q       <= '0;
      count_q      <= '0;
      rev_q        <= 1'b0;
      idx_q        <= '0;
      last_q       <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        group_size_q <= cfg_wdata_i;
      end
      fill_q  <= fill_d;
      count_q <= count_d;
      rev_q   <= rev_d;
      idx_q   <= idx_d;
      if (cmd_i.read) begin
        last_q <= idx_last;
      end
    end
  end

  // The fill count never exceeds MaxGroup-1 before a write, so it always addresses the store.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      store_mem[fill_q[grs_pkg::AddrWidth-1:0]] <= value_i;
    end
    if (cmd_i.read) begin
      rd_data_q <= store_mem[rd_addr];
    end
  end

  assign out_value_o = rd_data_q;
  assign run_end_o   = last_q;

endmodule

`default_nettype wire

@@ hw/rtl/grs_controller.sv @@
// Controller: state machine sequencing input acceptance, store reads and result transfers.
`timescale 1ns / 1ps
`default_nettype none

module grs_controller (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  input  wire grs_pkg::grs_sts_t  sts_i,
  output grs_pkg::grs_cmd_t       cmd_o
);

  grs_pkg::grs_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= grs_pkg::StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    cmd_o       = '0;
    case (state_q)
      grs_pkg::StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          if (sts_i.emit_go) begin
            state_d = grs_pkg::StRead;
          end
        end
      end
      grs_pkg::StRead: begin
        cmd_o.read = 1'b1;
        state_d    = grs_pkg::StShow;
      end
      grs_pkg::StShow: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          cmd_o.advance = 1'b1;
          state_d       = sts_i.last ? grs_pkg::StIdle : grs_pkg::StRead;
        end
      end
      default: begin
        state_d = grs_pkg::StIdle;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ hw/rtl/group_reverse_sequence_unit.sv @@
// Top level of the group reverse sequence unit: controller plus datapath.
//
// The unit takes a stream of signed 32-bit values on the slave channel, one value per
// transfer, with tlast marking the final value of a sequence. Values are collected in a
// 16-entry group store. Once group_size values are held, the whole group leaves on the
// master channel last value first; when tlast arrives with the group still incomplete,
// the partial group leaves in its original order. The master tlast is high on the last
// result released by one input transfer. A group size of zero or one passes values
// through, and a size above 16 counts as 16. The size register is written through
// cfg_we_i / cfg_wdata_i; the user must do so only while the unit is idle, since the
// block itself does not enforce it. An input that completes no group leaves the unit
// idle and ready for the next input. An input that releases n results moves the unit
// to a store read (StRead) and then to the output register (StShow), where the first
// result is offered. Each further result repeats the store read, paced by the
// single registered read port of the group store. One input is handled at a time: the
// slave tready stays low until the last result of a run has been transferred.
// When the receiver stalls, the result is held in the output register unchanged.
// Reset empties the store (fill count zero), returns to idle and sets group_size to 2.
`timescale 1ns / 1ps
`default_nettype none

module group_reverse_sequence_unit (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // Configuration: group_size register.
  input  wire logic                          cfg_we_i,
  input  wire logic [grs_pkg::SizeWidth-1:0] cfg_wdata_i,
  // Input stream.
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire logic [grs_pkg::DataWidth-1:0] s_axis_tdata,   // [31:0] value
  input  wire logic                          s_axis_tlast,   // is_final
  // Result stream.
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  output logic [grs_pkg::DataWidth-1:0]      m_axis_tdata,   // [31:0] out_value
  output logic                               m_axis_tlast    // run_end
);

  grs_pkg::grs_cmd_t cmd;
  grs_pkg::grs_sts_t sts;

  // The controller owns both handshakes; the datapath only follows commands.
  grs_controller u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  grs_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .value_i     (s_axis_tdata),
    .is_final_i  (s_axis_tlast),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_value_o (m_axis_tdata),
    .run_end_o   (m_axis_tlast)
  );

endmodule

`default_nettype wire

@@ tb/sv/group_reverse_sequence_unit_tb.sv @@
// Self-checking testbench for the group reverse sequence unit.
`timescale 1ns / 1ps

module group_reverse_sequence_unit_tb;

  localparam int LongHoldCycles = 300;
  localparam int WatchdogLimit  = 2000;
  localparam int SettleCycles   = 8;
  localparam int RandomPhases   = 8;
  localparam int ItemsPerPhase  = 26;

  // One transfer on the slave side: a data value and the end-of-sequence flag.
  typedef struct packed {
    logic [grs_pkg::DataWidth-1:0] value;
    logic                          is_final;
  } seq_item_t;

  // One transfer on the master side.
  typedef struct packed {
    logic [grs_pkg::DataWidth-1:0] value;
    logic                          run_end;
  } emit_item_t;

  logic                          clk_i         = 1'b0;
  logic                          rst_ni        = 1'b0;
  logic                          cfg_we_i      = 1'b0;
  logic [grs_pkg::SizeWidth-1:0] cfg_wdata_i   = '0;
  logic                          s_axis_tvalid = 1'b0;
  logic                          s_axis_tready;
  logic [grs_pkg::DataWidth-1:0] s_axis_tdata  = '0;   // [31:0] value
  logic                          s_axis_tlast  = 1'b0; // is_final
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 1'b0;
  logic [grs_pkg::DataWidth-1:0] m_axis_tdata;         // [31:0] out_value
  logic                          m_axis_tlast;         // run_end

  group_reverse_sequence_unit u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #2 clk_i = ~clk_i;

  // Values waiting to be offered on the slave side, and results the unit owes us.
  seq_item_t  value_q[$];
  emit_item_t emit_q[$];

  // Our own copy of the unit's state: the held group, its fill level and the size register.
  logic [grs_pkg::DataWidth-1:0] group_mirror [grs_pkg::MaxGroup];
  int unsigned                   mirror_fill = 0;
  logic [grs_pkg::SizeWidth-1:0] mirror_size = grs_pkg::GroupSizeReset;

  // Knobs that the stimulus sequence turns between phases.
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_requests  = 0;
  int unsigned hold_served    = 0;
  int unsigned hold_left      = 0;

  int unsigned mismatch_count = 0;
  int unsigned quiet_cycles   = 0;

  seq_item_t on_bus;

  // Predict what one accepted value releases. The value is always stored first. A group
  // that reaches the size leaves newest first; otherwise a final value flushes the held
  // partial group oldest first. Size zero acts as one and anything above the store
  // depth acts as the depth. Lowering the size mid-group makes the next value flush
  // everything held, since the comparison is "at least".
  function automatic void reverse_group_step(input seq_item_t item);
    int unsigned limit;
    int unsigned held;
    emit_item_t  res;
    limit = int'(mirror_size);
    if (limit == 0) begin
      limit = 1;
    end
    if (limit > grs_pkg::MaxGroup) begin
      limit = grs_pkg::MaxGroup;
    end
    if (mirror_fill < grs_pkg::MaxGroup) begin
      group_mirror[mirror_fill] = item.value;
      mirror_fill++;
    end
    held = mirror_fill;
    if (held >= limit) begin
      for (int unsigned k = 0; k < held; k++) begin
        res.value   = group_mirror[held - 1 - k];
        res.run_end = (k + 1 == held);
        emit_q.push_back(res);
      end
      mirror_fill = 0;
    end else if (item.is_final) begin
      for (int unsigned k = 0; k < held; k++) begin
        res.value   = group_mirror[k];
        res.run_end = (k + 1 == held);
        emit_q.push_back(res);
      end
      mirror_fill = 0;
    end
  endfunction

  // Sender. A transfer completes when tvalid and tready are both high at the edge; the
  // prediction is made right there from the item that sat on the bus. A new item is only
  // loaded once the previous one is gone, and the random idle percentage decides
  // whether the slot stays empty for this cycle.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        reverse_group_step(on_bus);
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (value_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          on_bus        = value_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= on_bus.value;
          s_axis_tlast  <= on_bus.is_final;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver and checker. Each result transfer is compared with the oldest prediction.
  // A long hold-off, requested by the stimulus sequence, keeps tready low for a fixed
  // count so that the unit backs up and stops taking input.
  always @(posedge clk_i) begin
    emit_item_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (emit_q.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("unexpected result: value %h run_end %b", m_axis_tdata, m_axis_tlast);
          end
        end else begin
          want = emit_q.pop_front();
          if (m_axis_tdata !== want.value || m_axis_tlast !== want.run_end) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $display("result mismatch: expected value %h run_end %b, got value %h run_end %b",
                       want.value, want.run_end, m_axis_tdata, m_axis_tlast);
            end
          end
        end
      end
      if (hold_requests != hold_served) begin
        hold_served   <= hold_requests;
        hold_left     <= LongHoldCycles;
        m_axis_tready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left     <= hold_left - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Watchdog: a stretch with no transfer on either side means the unit has hung.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WatchdogLimit) begin
        $display("watchdog: no transfer for %0d cycles", quiet_cycles);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  task automatic queue_value(input logic [grs_pkg::DataWidth-1:0] value,
                             input logic is_final);
    seq_item_t item;
    item.value    = value;
    item.is_final = is_final;
    value_q.push_back(item);
  endtask

  // Wait until every value has been taken and every predicted result has arrived, then
  // let the unit settle so that it can finish an input that released nothing.
  task automatic wait_drained();
    do begin
      @(negedge clk_i);
    end while (value_q.size() != 0 || s_axis_tvalid || emit_q.size() != 0);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  // Size register write; only called while the unit is idle, so the mirror can follow
  // at once.
  task automatic write_group_size(input logic [grs_pkg::SizeWidth-1:0] size);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= size;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    mirror_size = size;
    @(negedge clk_i);
  endtask

  function automatic logic [grs_pkg::DataWidth-1:0] pick_value();
    case ($urandom_range(9))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return '0;
      3:       return '1;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    logic [grs_pkg::SizeWidth-1:0] phase_sizes [RandomPhases];
    phase_sizes = '{5'd4, 5'd16, 5'd31, 5'd5, 5'd1, 5'd0, 5'd9, 5'd3};

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part, starting from the reset size of two. The extremes of the value
    // range pair up and come back swapped; a final value alone flushes a single result;
    // a final value that completes the group still comes back reversed.
    queue_value(32'h7FFF_FFFF, 1'b0);
    queue_value(32'h8000_0000, 1'b0);
    queue_value(32'hFFFF_FFFF, 1'b1);
    queue_value(32'h0000_0000, 1'b0);
    queue_value(32'h0000_0001, 1'b1);
    wait_drained();

    // Size one and size zero both pass values straight through.
    write_group_size(5'd1);
    queue_value(32'hA5A5_A5A5, 1'b0);
    queue_value(32'h5A5A_5A5A, 1'b1);
    wait_drained();
    write_group_size(5'd0);
    queue_value(32'h1234_5678, 1'b0);
    queue_value(32'hFFFF_FFFE, 1'b1);
    wait_drained();

    // A partial group ended by a final value keeps its original order.
    write_group_size(5'd3);
    queue_value(32'h0000_00AA, 1'b0);
    queue_value(32'h0000_00BB, 1'b1);
    wait_drained();

    // Lowering the size mid-group: five values are held under size eight, the size drops
    // to three, and the next value releases all six reversed.
    write_group_size(5'd8);
    for (int i = 0; i < 5; i++) begin
      queue_value(32'hC0DE_0000 + i, 1'b0);
    end
    wait_drained();
    write_group_size(5'd3);
    queue_value(32'hC0DE_0005, 1'b0);
    wait_drained();

    // Random phases. Each phase ends with the sender paused until all results are in,
    // and the size is then changed with whatever partial group is still held. One phase
    // opens with a long receiver hold-off while values keep coming.
    for (int p = 0; p < RandomPhases; p++) begin
      write_group_size(phase_sizes[p]);
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 64; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 64; end
        default: begin send_idle_pct = 26; recv_stall_pct = 26; end
      endcase
      if (p == 2) begin
        hold_requests++;
      end
      for (int i = 0; i < ItemsPerPhase; i++) begin
        queue_value(pick_value(), ($urandom_range(99) < 12));
      end
      wait_drained();
    end

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    wait_drained();
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
